[design/tmq_pkg.sv]
// Shared types and constants of the touch move qualifier.
package tmq_pkg;

   localparam int COORD_BITS    = 12;
   localparam int ROOT_STEPS    = 16;
   localparam int DELTA_BITS    = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * DELTA_BITS;
   localparam int SUM_BITS      = SQ_BITS + 1;
   localparam int ROOT_IN_BITS  = 2 * ROOT_STEPS;
   localparam int REM_BITS      = ROOT_STEPS + 4;
   localparam int STEP_CNT_BITS = $clog2(ROOT_STEPS);
   localparam int PX_BITS       = 12;
   localparam int UM_BITS       = 20;
   localparam int THR_BITS      = 16;
   localparam int HOLD_BITS     = 8;
   localparam int TIME_BITS     = 32;
   localparam int KIND_BITS     = 2;
   localparam int DIST_BITS     = ROOT_STEPS + UM_BITS;
   localparam int LIM_BITS      = THR_BITS + PX_BITS;
   localparam int CMP_BITS      = (DIST_BITS > LIM_BITS) ? DIST_BITS : LIM_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = UM_BITS;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_PX  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_UM  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLDOFF   = 2'd3;

   localparam logic [PX_BITS-1:0]   WIDTH_PX_RESET  = 12'd800;
   localparam logic [UM_BITS-1:0]   WIDTH_UM_RESET  = 20'd154080;
   localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 16'd1000;
   localparam logic [HOLD_BITS-1:0] HOLDOFF_RESET   = 8'd10;

   // event kinds
   localparam logic [KIND_BITS-1:0] KIND_SETTLED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_MOVE    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 2'd2;

   typedef struct packed {
      logic                 capture;
      logic                 diff;
      logic                 sq_x;
      logic                 sq_y;
      logic                 sum;
      logic                 root_step;
      logic                 mul_dist;
      logic                 mul_limit;
      logic                 set_anchor;
      logic                 load_holdoff;
      logic                 dec_holdoff;
      logic                 emit;
      logic [KIND_BITS-1:0] kind;
   } dp_cmd_type;

   typedef struct packed {
      logic holdoff_zero;
      logic pressed;
      logic root_last;
      logic below_limit;
      logic out_free;
   } dp_status_type;

endpackage

[design/touch_move_qualifier.sv]
// Top level of the touch move qualifier: sequencer and datapath.
// Qualifies single-touch panel scans into settled, move and release events.
// One scan item is handled at a time. An item that needs a distance passes
// through the difference, square, sum, a 16-step bit-serial square root, and
// the scale and compare steps; it gives a result unless the contact was
// already settled and stays so. A release goes from the decision straight to
// the output step. Items that only update the contact status or the holdoff
// count give no result. The result sits in an output register, so the next
// item is taken while it waits to be read; a result that finds that register
// full and stalled holds the sequencer until it drains.
// Configuration may be written whenever no item is in progress.
module touch_move_qualifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [tmq_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tmq_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_pressed,
   input  logic [tmq_pkg::COORD_BITS-1:0]        req_pos_x,
   input  logic [tmq_pkg::COORD_BITS-1:0]        req_pos_y,
   input  logic [tmq_pkg::COORD_BITS-1:0]        req_pressure,
   input  logic [tmq_pkg::TIME_BITS-1:0]         req_sample_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tmq_pkg::KIND_BITS-1:0]         rsp_event_kind,
   output logic [tmq_pkg::COORD_BITS-1:0]        rsp_out_x,
   output logic [tmq_pkg::COORD_BITS-1:0]        rsp_out_y,
   output logic [tmq_pkg::COORD_BITS-1:0]        rsp_out_pressure,
   output logic signed [tmq_pkg::DELTA_BITS-1:0] rsp_move_dx,
   output logic signed [tmq_pkg::DELTA_BITS-1:0] rsp_move_dy,
   output logic [tmq_pkg::TIME_BITS-1:0]         rsp_event_time
);
   import tmq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tmq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pressed      (req_pressed),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pressure     (req_pressure),
      .req_sample_time  (req_sample_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_pressure (rsp_out_pressure),
      .rsp_move_dx      (rsp_move_dx),
      .rsp_move_dy      (rsp_move_dy),
      .rsp_event_time   (rsp_event_time)
   );

endmodule

[design/tmq_ctrl.sv]
// Sequencer of the touch move qualifier: contact status and step order.
module tmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tmq_pkg::dp_status_type status,
   output tmq_pkg::dp_cmd_type    cmd
);
   import tmq_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_DIFF   = 4'd2;
   localparam logic [3:0] S_SQX    = 4'd3;
   localparam logic [3:0] S_SQY    = 4'd4;
   localparam logic [3:0] S_SUM    = 4'd5;
   localparam logic [3:0] S_ROOT   = 4'd6;
   localparam logic [3:0] S_MULA   = 4'd7;
   localparam logic [3:0] S_MULB   = 4'd8;
   localparam logic [3:0] S_CMP    = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   localparam logic [1:0] C_NONE     = 2'd0;
   localparam logic [1:0] C_TOUCHING = 2'd1;
   localparam logic [1:0] C_SETTLED  = 2'd2;
   localparam logic [1:0] C_MOVING   = 2'd3;

   logic [3:0]           state_ff, state_in;
   logic [1:0]           contact_ff, contact_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      contact_in = contact_ff;
      kind_in    = kind_ff;
      cmd        = '0;
      cmd.kind   = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!status.holdoff_zero) begin
               cmd.dec_holdoff = 1'b1;
               state_in        = S_IDLE;
            end else if (!status.pressed) begin
               if (contact_ff == C_NONE) begin
                  state_in = S_IDLE;
               end else begin
                  contact_in = C_NONE;
                  kind_in    = KIND_RELEASE;
                  state_in   = S_EMIT;
               end
            end else if (contact_ff == C_NONE) begin
               cmd.set_anchor = 1'b1;
               contact_in     = C_TOUCHING;
               state_in       = S_IDLE;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            cmd.mul_dist = 1'b1;
            state_in     = S_MULB;
         end
         S_MULB: begin
            cmd.mul_limit = 1'b1;
            state_in      = S_CMP;
         end
         S_CMP: begin
            if (status.below_limit) begin
               if (contact_ff == C_SETTLED) begin
                  state_in = S_IDLE;
               end else begin
                  contact_in = C_SETTLED;
                  kind_in    = KIND_SETTLED;
                  state_in   = S_EMIT;
               end
            end else begin
               cmd.set_anchor   = 1'b1;
               cmd.load_holdoff = 1'b1;
               contact_in       = C_MOVING;
               kind_in          = KIND_MOVE;
               state_in         = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register can take the item
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         contact_ff <= C_NONE;
         kind_ff    <= KIND_SETTLED;
      end else begin
         state_ff   <= state_in;
         contact_ff <= contact_in;
         kind_ff    <= kind_in;
      end
   end

endmodule

[design/tmq_dp.sv]
// Datapath of the touch move qualifier: registers, square root, scaling, output.
module tmq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tmq_pkg::dp_cmd_type                  cmd,
   output tmq_pkg::dp_status_type               status,
   input  logic                                 csr_write,
   input  logic [tmq_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [tmq_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 req_pressed,
   input  logic [tmq_pkg::COORD_BITS-1:0]       req_pos_x,
   input  logic [tmq_pkg::COORD_BITS-1:0]       req_pos_y,
   input  logic [tmq_pkg::COORD_BITS-1:0]       req_pressure,
   input  logic [tmq_pkg::TIME_BITS-1:0]        req_sample_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tmq_pkg::KIND_BITS-1:0]        rsp_event_kind,
   output logic [tmq_pkg::COORD_BITS-1:0]       rsp_out_x,
   output logic [tmq_pkg::COORD_BITS-1:0]       rsp_out_y,
   output logic [tmq_pkg::COORD_BITS-1:0]       rsp_out_pressure,
   output logic signed [tmq_pkg::DELTA_BITS-1:0] rsp_move_dx,
   output logic signed [tmq_pkg::DELTA_BITS-1:0] rsp_move_dy,
   output logic [tmq_pkg::TIME_BITS-1:0]        rsp_event_time
);
   import tmq_pkg::*;

   // configuration
   logic [PX_BITS-1:0]   width_px_ff;
   logic [UM_BITS-1:0]   width_um_ff;
   logic [THR_BITS-1:0]  threshold_ff;
   logic [HOLD_BITS-1:0] holdoff_cfg_ff;

   // sample and state
   logic                  pressed_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff, p_ff;
   logic [TIME_BITS-1:0]  time_ff;
   logic [COORD_BITS-1:0] anchor_x_ff, anchor_y_ff;
   logic [HOLD_BITS-1:0]  holdoff_ff;

   // arithmetic
   logic signed [DELTA_BITS-1:0] dx_ff, dy_ff;
   logic signed [DELTA_BITS-1:0] dx_in, dy_in;
   logic signed [SQ_BITS-1:0]    sq_x_in, sq_y_in;
   logic [SQ_BITS-1:0]           sq_x_ff, sq_y_ff;
   logic [SUM_BITS-1:0]          sum_in;
   logic [ROOT_IN_BITS-1:0]      op_ff;
   logic [ROOT_STEPS-1:0]        root_ff;
   logic [REM_BITS-1:0]          rem_ff, rem_sh, trial;
   logic [STEP_CNT_BITS-1:0]     step_ff;
   logic [DIST_BITS-1:0]         dist_ff;
   logic [LIM_BITS-1:0]          limit_ff;
   logic [PX_BITS-1:0]           divisor;

   // output register
   logic                          rsp_valid_ff;
   logic [KIND_BITS-1:0]          kind_ff;
   logic [COORD_BITS-1:0]         out_x_ff, out_y_ff, out_p_ff;
   logic signed [DELTA_BITS-1:0]  out_dx_ff, out_dy_ff;
   logic [TIME_BITS-1:0]          out_time_ff;

   assign dx_in   = $signed({1'b0, x_ff}) - $signed({1'b0, anchor_x_ff});
   assign dy_in   = $signed({1'b0, anchor_y_ff}) - $signed({1'b0, y_ff});
   assign sq_x_in = SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
   assign sq_y_in = SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
   assign sum_in  = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff);

   assign rem_sh  = {rem_ff[REM_BITS-3:0], op_ff[ROOT_IN_BITS-1 -: 2]};
   assign trial   = REM_BITS'({root_ff, 2'b01});
   // a zero width divides as one
   assign divisor = (width_px_ff == '0) ? PX_BITS'(1) : width_px_ff;

   assign status.holdoff_zero = (holdoff_ff == '0);
   assign status.pressed      = pressed_ff;
   assign status.root_last    = (step_ff == STEP_CNT_BITS'(ROOT_STEPS - 1));
   // floor(d / w) < t exactly when d < t * w
   assign status.below_limit  = (CMP_BITS'(dist_ff) < CMP_BITS'(limit_ff));
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_px_ff    <= WIDTH_PX_RESET;
         width_um_ff    <= WIDTH_UM_RESET;
         threshold_ff   <= THRESHOLD_RESET;
         holdoff_cfg_ff <= HOLDOFF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH_PX:  width_px_ff    <= csr_data[PX_BITS-1:0];
            CSR_WIDTH_UM:  width_um_ff    <= csr_data[UM_BITS-1:0];
            CSR_THRESHOLD: threshold_ff   <= csr_data[THR_BITS-1:0];
            CSR_HOLDOFF:   holdoff_cfg_ff <= csr_data[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         holdoff_ff  <= '0;
      end else begin
         if (cmd.set_anchor) begin
            anchor_x_ff <= x_ff;
            anchor_y_ff <= y_ff;
         end
         if (cmd.load_holdoff) begin
            holdoff_ff <= holdoff_cfg_ff;
         end else if (cmd.dec_holdoff) begin
            holdoff_ff <= holdoff_ff - HOLD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pressed_ff <= req_pressed;
         x_ff       <= req_pos_x;
         y_ff       <= req_pos_y;
         p_ff       <= req_pressure;
         time_ff    <= req_sample_time;
      end
      if (cmd.diff) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.sq_x) begin
         sq_x_ff <= $unsigned(sq_x_in);
      end
      if (cmd.sq_y) begin
         sq_y_ff <= $unsigned(sq_y_in);
      end
      if (cmd.sum) begin
         op_ff   <= ROOT_IN_BITS'(sum_in);
         root_ff <= '0;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.root_step) begin
         // one result bit per step, two operand bits in
         op_ff   <= op_ff << 2;
         step_ff <= step_ff + STEP_CNT_BITS'(1);
         if (rem_sh >= trial) begin
            root_ff <= {root_ff[ROOT_STEPS-2:0], 1'b1};
            rem_ff  <= rem_sh - trial;
         end else begin
            root_ff <= {root_ff[ROOT_STEPS-2:0], 1'b0};
            rem_ff  <= rem_sh;
         end
      end
      if (cmd.mul_dist) begin
         dist_ff <= DIST_BITS'(root_ff) * DIST_BITS'(width_um_ff);
      end
      if (cmd.mul_limit) begin
         limit_ff <= LIM_BITS'(threshold_ff) * LIM_BITS'(divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff     <= cmd.kind;
         out_time_ff <= time_ff;
         unique case (cmd.kind)
            KIND_RELEASE: begin
               out_x_ff  <= anchor_x_ff;
               out_y_ff  <= anchor_y_ff;
               out_p_ff  <= '0;
               out_dx_ff <= '0;
               out_dy_ff <= '0;
            end
            KIND_MOVE: begin
               out_x_ff  <= x_ff;
               out_y_ff  <= y_ff;
               out_p_ff  <= p_ff;
               out_dx_ff <= dx_ff;
               out_dy_ff <= dy_ff;
            end
            default: begin
               out_x_ff  <= x_ff;
               out_y_ff  <= y_ff;
               out_p_ff  <= p_ff;
               out_dx_ff <= '0;
               out_dy_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_pressure = out_p_ff;
   assign rsp_move_dx      = out_dx_ff;
   assign rsp_move_dy      = out_dy_ff;
   assign rsp_event_time   = out_time_ff;

endmodule

[bench/touch_move_qualifier_tb.sv]
// Self-checking testbench of the touch move qualifier: scan items against a built-in predictor.
module touch_move_qualifier_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tmq_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STUCK_LIMIT   = 4000;
   localparam int MAX_COORD     = (1 << COORD_BITS) - 1;
   localparam int MAX_UM        = (1 << UM_BITS) - 1;

   typedef enum logic [1:0] {NO_TOUCH, TOUCHING, SETTLED, MOVING} contact_type;

   typedef struct packed {
      logic                  pressed;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] pressure;
      logic [TIME_BITS-1:0]  stamp;
      logic                  drain;
   } scan_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic [COORD_BITS-1:0]        pressure;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
      logic [TIME_BITS-1:0]         stamp;
   } touch_event_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_pressed = 1'b0;
   logic [COORD_BITS-1:0]       req_pos_x = '0;
   logic [COORD_BITS-1:0]       req_pos_y = '0;
   logic [COORD_BITS-1:0]       req_pressure = '0;
   logic [TIME_BITS-1:0]        req_sample_time = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]        rsp_event_kind;
   logic [COORD_BITS-1:0]       rsp_out_x;
   logic [COORD_BITS-1:0]       rsp_out_y;
   logic [COORD_BITS-1:0]       rsp_out_pressure;
   logic signed [DELTA_BITS-1:0] rsp_move_dx;
   logic signed [DELTA_BITS-1:0] rsp_move_dy;
   logic [TIME_BITS-1:0]        rsp_event_time;

   touch_move_qualifier dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pressed      (req_pressed),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pressure     (req_pressure),
      .req_sample_time  (req_sample_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_pressure (rsp_out_pressure),
      .rsp_move_dx      (rsp_move_dx),
      .rsp_move_dy      (rsp_move_dy),
      .rsp_event_time   (rsp_event_time)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the configuration and the contact state
   logic [PX_BITS-1:0]    cfg_width_px  = WIDTH_PX_RESET;
   logic [UM_BITS-1:0]    cfg_width_um  = WIDTH_UM_RESET;
   logic [THR_BITS-1:0]   cfg_threshold = THRESHOLD_RESET;
   logic [HOLD_BITS-1:0]  cfg_holdoff   = HOLDOFF_RESET;
   contact_type           contact       = NO_TOUCH;
   logic [COORD_BITS-1:0] anchor_x      = '0;
   logic [COORD_BITS-1:0] anchor_y      = '0;
   logic [HOLD_BITS-1:0]  holdoff_left  = '0;

   scan_type        scan_queue[$];
   touch_event_type pending_events[$];
   scan_type        on_bus;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              error_count = 0;
   int              stuck_cycles = 0;
   int unsigned     next_stamp;

   function automatic logic [ROOT_STEPS-1:0] int_root(logic [ROOT_IN_BITS-1:0] v);
      logic [ROOT_STEPS-1:0] root;
      logic [39:0]           rem;
      logic [39:0]           trial;
      root = '0;
      rem  = '0;
      for (int k = ROOT_STEPS - 1; k >= 0; k--) begin
         root  = root << 1;
         rem   = (rem << 2) | 40'(v[2*k +: 2]);
         trial = 40'({root, 1'b1});
         if (rem >= trial) begin
            root[0] = 1'b1;
            rem     = rem - trial;
         end
      end
      return root;
   endfunction

   // advance the contact state by one scan and queue the event it causes, if any
   function automatic void qualify_scan(scan_type s);
      int                      ix;
      int                      iy;
      logic [ROOT_IN_BITS-1:0] sq;
      logic [63:0]             divisor;
      logic [63:0]             dist_um;
      touch_event_type         ev;
      ev = '0;
      ev.stamp = s.stamp;
      if (holdoff_left != 0) begin
         holdoff_left = holdoff_left - 1'b1;
         return;
      end
      if (!s.pressed) begin
         if (contact == NO_TOUCH)
            return;
         contact  = NO_TOUCH;
         ev.kind  = KIND_RELEASE;
         ev.x     = anchor_x;
         ev.y     = anchor_y;
         pending_events.push_back(ev);
         return;
      end
      if (contact == NO_TOUCH) begin
         anchor_x = s.x;
         anchor_y = s.y;
         contact  = TOUCHING;
         return;
      end
      ix      = int'(s.x) - int'(anchor_x);
      iy      = int'(anchor_y) - int'(s.y);
      sq      = ROOT_IN_BITS'(ix * ix + iy * iy);
      divisor = (cfg_width_px == 0) ? 64'd1 : 64'(cfg_width_px);
      dist_um = 64'(int_root(sq)) * 64'(cfg_width_um) / divisor;
      ev.x        = s.x;
      ev.y        = s.y;
      ev.pressure = s.pressure;
      if (dist_um < 64'(cfg_threshold)) begin
         if (contact == SETTLED)
            return;
         contact = SETTLED;
         ev.kind = KIND_SETTLED;
         pending_events.push_back(ev);
         return;
      end
      contact      = MOVING;
      anchor_x     = s.x;
      anchor_y     = s.y;
      holdoff_left = cfg_holdoff;
      ev.kind      = KIND_MOVE;
      ev.dx        = ix[DELTA_BITS-1:0];
      ev.dy        = iy[DELTA_BITS-1:0];
      pending_events.push_back(ev);
   endfunction

   task automatic flag_mismatch(string what);
      error_count++;
      if (error_count <= 100)
         $display("%0t ns: %s", $time, what);
   endtask

   task automatic check_field(string name, logic signed [63:0] got, logic signed [63:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // sender: hold a stalled item, otherwise present the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            qualify_scan(on_bus);
         if (!req_valid || !req_stall) begin
            if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(scan_queue[0].drain && pending_events.size() != 0)) begin
               on_bus          = scan_queue.pop_front();
               req_valid       <= 1'b1;
               req_pressed     <= on_bus.pressed;
               req_pos_x       <= on_bus.x;
               req_pos_y       <= on_bus.y;
               req_pressure    <= on_bus.pressure;
               req_sample_time <= on_bus.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall at random and compare each accepted item with the oldest expectation
   always @(posedge clock) begin
      touch_event_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               flag_mismatch("result item with no expectation waiting");
            end else begin
               want = pending_events.pop_front();
               check_field("event_kind", rsp_event_kind, want.kind);
               check_field("out_x", rsp_out_x, want.x);
               check_field("out_y", rsp_out_y, want.y);
               check_field("out_pressure", rsp_out_pressure, want.pressure);
               check_field("move_dx", $signed(rsp_move_dx), $signed(want.dx));
               check_field("move_dy", $signed(rsp_move_dy), $signed(want.dy));
               check_field("event_time", rsp_event_time, want.stamp);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
      if (v < 0)
         return '0;
      if (v > MAX_COORD)
         return MAX_COORD[COORD_BITS-1:0];
      return v[COORD_BITS-1:0];
   endfunction

   task automatic queue_scan(bit pressed, int x, int y, int p, logic [TIME_BITS-1:0] stamp_val,
                             bit drain);
      scan_type s;
      s.pressed  = pressed;
      s.x        = x[COORD_BITS-1:0];
      s.y        = y[COORD_BITS-1:0];
      s.pressure = p[COORD_BITS-1:0];
      s.stamp    = stamp_val;
      s.drain    = drain;
      scan_queue.push_back(s);
   endtask

   task automatic queue_random_scan(bit pressed, int x, int y, bit drain);
      if ($urandom_range(49) == 0)
         next_stamp = $urandom();
      else
         next_stamp += $urandom_range(1, 5000);
      queue_scan(pressed, x, y, $urandom_range(MAX_COORD), next_stamp, drain);
   endtask

   // press, wander around with some spread, then lift
   task automatic queue_gesture();
      int x;
      int y;
      int spread;
      x = ($urandom_range(7) == 0) ? $urandom_range(1) * MAX_COORD : $urandom_range(MAX_COORD);
      y = ($urandom_range(7) == 0) ? $urandom_range(1) * MAX_COORD : $urandom_range(MAX_COORD);
      queue_random_scan(1'b1, x, y, $urandom_range(39) == 0);
      case ($urandom_range(4))
         0: spread = 0;
         1: spread = 2;
         2: spread = 8;
         3: spread = 40;
         default: spread = 700;
      endcase
      repeat ($urandom_range(1, 14)) begin
         if ($urandom_range(11) == 0) begin
            x = $urandom_range(MAX_COORD);
            y = $urandom_range(MAX_COORD);
         end else begin
            x = clamp_coord(x + int'($urandom_range(2 * spread)) - spread);
            y = clamp_coord(y + int'($urandom_range(2 * spread)) - spread);
         end
         queue_random_scan(1'b1, x, y, 1'b0);
      end
      repeat ($urandom_range(1, 2))
         queue_random_scan(1'b0, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD), 1'b0);
   endtask

   task automatic fill_random(int count);
      while (scan_queue.size() < count) begin
         if ($urandom_range(9) == 0)
            queue_random_scan($urandom_range(1), $urandom_range(MAX_COORD),
                              $urandom_range(MAX_COORD), 1'b0);
         else
            queue_gesture();
      end
   endtask

   // wait until every item is taken and answered, then let the block finish silent items
   task automatic wait_quiet();
      @(negedge clock);
      while (scan_queue.size() != 0 || req_valid || pending_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CSR_DATA_BITS-1:0];
      case (idx)
         CSR_WIDTH_PX:  cfg_width_px  = val[PX_BITS-1:0];
         CSR_WIDTH_UM:  cfg_width_um  = val[UM_BITS-1:0];
         CSR_THRESHOLD: cfg_threshold = val[THR_BITS-1:0];
         CSR_HOLDOFF:   cfg_holdoff   = val[HOLD_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(int px, int um, int thr, int hold, int send_pct, int recv_pct);
      wait_quiet();
      write_reg(CSR_WIDTH_PX, px);
      write_reg(CSR_WIDTH_UM, um);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_HOLDOFF, hold);
      @(posedge clock);
      csr_write      <= 1'b0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      int px;
      int um;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      next_stamp = $urandom();

      // directed: distance of exactly the threshold moves, holdoff of two
      apply_setting(3, 1000, 1000, 2, 0, 0);
      queue_scan(0, 0, 0, 0, 32'd0, 0);
      queue_scan(1, 0, 0, 0, 32'd1, 0);
      queue_scan(1, 0, 0, 5, 32'd2, 0);
      queue_scan(1, 2, 2, 7, 32'd3, 0);
      queue_scan(1, 3, 0, 9, 32'd4, 0);
      queue_scan(0, 3, 0, 0, 32'd5, 0);
      queue_scan(1, MAX_COORD, MAX_COORD, MAX_COORD, 32'd6, 0);
      queue_scan(1, MAX_COORD, 0, MAX_COORD, 32'd7, 0);
      queue_scan(1, 17, 99, 1, 32'd8, 0);
      queue_scan(0, 0, 0, 0, 32'd9, 0);
      queue_scan(1, 0, MAX_COORD, 100, 32'd10, 0);
      queue_scan(1, 5, 5, 5, 32'd11, 0);
      queue_scan(1, 6, 6, 6, 32'd12, 0);
      queue_scan(1, 0, MAX_COORD, 200, 32'd13, 0);
      queue_scan(0, 1234, 2345, 3456, 32'hFFFF_FFFF, 0);
      queue_scan(0, 0, 0, 0, 32'd14, 0);
      queue_scan(1, MAX_COORD, MAX_COORD, MAX_COORD, 32'd15, 1);
      queue_scan(1, MAX_COORD, 0, 1, 32'd16, 0);
      queue_scan(1, 0, 0, 0, 32'd17, 0);
      queue_scan(1, 0, 0, 0, 32'd18, 0);
      queue_scan(1, MAX_COORD - 1, 1, 2, 32'd19, 0);
      queue_scan(0, 0, 0, 0, 32'd20, 0);
      queue_scan(1, 100, 100, 300, 32'd21, 0);
      queue_scan(0, 0, 0, 0, 32'd22, 0);

      apply_setting(WIDTH_PX_RESET, WIDTH_UM_RESET, THRESHOLD_RESET, HOLDOFF_RESET, 0, 0);
      fill_random(250);
      apply_setting(1, MAX_UM, 65535, 0, 83, 0);
      fill_random(200);
      apply_setting(MAX_COORD, 1, 1, 1, 0, 83);
      fill_random(200);
      // zero pixel width divides by one; zero threshold makes every distance a move
      apply_setting(0, 1000, 0, 3, 35, 35);
      fill_random(200);
      apply_setting(MAX_COORD, MAX_UM, 2000, 255, 0, 0);
      fill_random(120);
      for (int i = 0; i < 3; i++) begin
         px = $urandom_range(50, MAX_COORD);
         um = px * $urandom_range(20, 400);
         if (um > MAX_UM)
            um = MAX_UM;
         case (i)
            0: apply_setting(px, um, $urandom_range(5000), $urandom_range(12), 83, 0);
            1: apply_setting(px, um, $urandom_range(5000), $urandom_range(12), 0, 83);
            default: apply_setting(px, um, $urandom_range(5000), $urandom_range(12), 35, 35);
         endcase
         fill_random(220);
      end

      wait_quiet();
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
